[design/per_source_rate_block_filter_top_macros.svh]
// Assertion macros used by the filter top design file.
`ifndef PER_SOURCE_RATE_BLOCK_FILTER_TOP_MACROS_SVH
`define PER_SOURCE_RATE_BLOCK_FILTER_TOP_MACROS_SVH

// Implication checked at every clock while out of reset.
`define PSRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked while out of reset.
`define PSRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/psrb_pkg.sv]
// ----------------------------------------------------------------------------
// psrb_pkg
// Types and constants of the per-source rate block filter.
// ----------------------------------------------------------------------------
package psrb_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int TABLE_WAYS    = 4;
	localparam int SETS          = TABLE_ENTRIES / TABLE_WAYS;
	localparam int SET_W         = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W         = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
	localparam int CLR_W         = SET_W + 1;

	localparam logic [15:0] IPV4_TYPE = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [31:0] HASH_MUL  = 32'h9E37_79B1;
	localparam logic [31:0] RATE_LIMIT_RST = 32'd1000;
	localparam logic [15:0] MIN_UDP_RST    = 16'd8;

	localparam logic CFG_RATE_LIMIT = 1'b0;
	localparam logic CFG_MIN_UDP    = 1'b1;

	localparam logic [2:0] RSN_NONE      = 3'd0;
	localparam logic [2:0] RSN_BLOCKED   = 3'd1;
	localparam logic [2:0] RSN_RATE      = 3'd2;
	localparam logic [2:0] RSN_SHORT_TCP = 3'd3;
	localparam logic [2:0] RSN_BAD_SYN   = 3'd4;
	localparam logic [2:0] RSN_SHORT_UDP = 3'd5;
	localparam logic [2:0] RSN_TINY_UDP  = 3'd6;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] ether_type;
		logic [31:0] source_address;
		logic [7:0]  ip_protocol;
		logic [3:0]  header_words;
		logic        syn_flag;
		logic        ack_flag;
		logic [3:0]  tcp_offset_words;
		logic [15:0] udp_length_field;
	} in_item_t;

	typedef struct packed {
		logic       verdict;
		logic [2:0] drop_reason;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic        blocked;
		logic [31:0] address;
		logic [31:0] count;
	} slot_t;

	typedef slot_t [TABLE_WAYS-1:0] set_row_t;

endpackage

[design/psrb_table.sv]
// ----------------------------------------------------------------------------
// psrb_table
// Set memory: one row holds all ways of a set; one read and one write port.
// Sweeps every row to invalid after reset.
// ----------------------------------------------------------------------------
module psrb_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [psrb_pkg::SET_W-1:0] rd_set,
	output psrb_pkg::set_row_t       rd_row,
	input  logic                     wr_en,
	input  logic [psrb_pkg::SET_W-1:0] wr_set,
	input  psrb_pkg::set_row_t       wr_row,
	output logic                     clr_done
);

	psrb_pkg::set_row_t mem [psrb_pkg::SETS];
	logic [psrb_pkg::CLR_W-1:0] clr_q;

	assign clr_done = clr_q[psrb_pkg::CLR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			if (clr_q[psrb_pkg::SET_W-1:0] == psrb_pkg::SET_W'(psrb_pkg::SETS - 1))
				clr_q <= {1'b1, {psrb_pkg::SET_W{1'b0}}};
			else
				clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_done)
			mem[clr_q[psrb_pkg::SET_W-1:0]] <= '0;
		else if (wr_en)
			mem[wr_set] <= wr_row;
		if (rd_en)
			rd_row <= mem[rd_set];
	end

endmodule

[design/per_source_rate_block_filter_top.sv]
// ----------------------------------------------------------------------------
// per_source_rate_block_filter_top
// Per-source rate limiter with frame sanity checks, one verdict per frame.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one frame's parsed header fields;
// output channel out_valid/out_stall carries verdict and drop reason.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// rate limit (index 0) and minimum UDP length (index 1).
// Flow: ST_HASH hash (multiply registered), ST_READ set read, ST_EVAL row
// back from memory, compare ways and write back, result registered.
// One frame is in flight at a time, for the read-modify-write of the set
// memory; the next frame is taken in the cycle the result transfers.
// After reset the table is swept, one set a cycle (TABLE_ENTRIES/TABLE_WAYS
// sets, 256 by default); no frame is taken until it is done.
// When the receiver stalls, the result holds in the output register and
// in_stall stays high until that result transfers.
// ----------------------------------------------------------------------------
`include "per_source_rate_block_filter_top_macros.svh"

module per_source_rate_block_filter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  psrb_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output psrb_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HASH = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_EVAL = 2'd3;

	logic [1:0] state_q;
	logic [31:0] rate_limit_q;
	logic [15:0] min_udp_q;
	psrb_pkg::in_item_t item_q;
	logic [31:0] hash_q;
	logic clr_done;
	psrb_pkg::set_row_t rd_row, wr_row;
	logic wr_en;
	logic [psrb_pkg::SET_W-1:0] set_idx;
	logic [2:0] reason;
	logic accept;

	assign cfg_ready = 1'b1;
	assign in_stall = !(clr_done && state_q == ST_IDLE && (!out_valid || !out_stall));
	assign accept = in_valid && !in_stall;
	assign set_idx = psrb_pkg::SET_W'(hash_q % psrb_pkg::SETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_limit_q <= psrb_pkg::RATE_LIMIT_RST;
			min_udp_q    <= psrb_pkg::MIN_UDP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psrb_pkg::CFG_RATE_LIMIT: rate_limit_q <= cfg_data;
				psrb_pkg::CFG_MIN_UDP:    min_udp_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= in_data;
		if (state_q == ST_HASH)
			hash_q <= (item_q.source_address ^ {16'h0, item_q.source_address[31:16]})
				* psrb_pkg::HASH_MUL;
	end

	psrb_table u_table (
		.clk(clk), .arst_n(arst_n),
		.rd_en(state_q == ST_READ), .rd_set(set_idx), .rd_row(rd_row),
		.wr_en(wr_en), .wr_set(set_idx), .wr_row(wr_row), .clr_done(clr_done)
	);

	// way search and checks
	always_comb begin
		logic hit, tracked, free_found;
		logic [psrb_pkg::WAY_W-1:0] hit_way, free_way;
		logic [32:0] nxt;
		logic [15:0] l4;
		hit = 1'b0; free_found = 1'b0;
		hit_way = '0; free_way = '0;
		for (int w = 0; w < psrb_pkg::TABLE_WAYS; w++) begin
			if (!hit && rd_row[w].valid && rd_row[w].address == item_q.source_address) begin
				hit = 1'b1;
				hit_way = psrb_pkg::WAY_W'(w);
			end
			if (!rd_row[w].valid && !free_found) begin
				free_found = 1'b1;
				free_way = psrb_pkg::WAY_W'(w);
			end
		end
		tracked = item_q.frame_length >= 16'd34 && item_q.ether_type == psrb_pkg::IPV4_TYPE;
		wr_row = rd_row;
		wr_en = 1'b0;
		reason = psrb_pkg::RSN_NONE;
		nxt = {1'b0, rd_row[hit_way].count} + 33'd1;
		l4 = 16'd14 + {10'd0, item_q.header_words, 2'b00};
		if (tracked) begin
			if (hit) begin
				if (rd_row[hit_way].blocked) begin
					reason = psrb_pkg::RSN_BLOCKED;
				end else if (nxt > {1'b0, rate_limit_q}) begin
					reason = psrb_pkg::RSN_RATE;
					wr_row[hit_way].blocked = 1'b1;
					wr_en = state_q == ST_EVAL;
				end else begin
					wr_row[hit_way].count = nxt[31:0];
					wr_en = state_q == ST_EVAL;
				end
			end else if (free_found) begin
				wr_row[free_way] = '{valid: 1'b1, blocked: 1'b0,
					address: item_q.source_address, count: 32'd1};
				wr_en = state_q == ST_EVAL;
			end
			if (reason == psrb_pkg::RSN_NONE) begin
				if (item_q.ip_protocol == psrb_pkg::PROTO_TCP) begin
					if ({1'b0, l4} + 17'd20 > {1'b0, item_q.frame_length})
						reason = psrb_pkg::RSN_SHORT_TCP;
					else if (item_q.syn_flag && !item_q.ack_flag && item_q.tcp_offset_words < 4'd5)
						reason = psrb_pkg::RSN_BAD_SYN;
				end else if (item_q.ip_protocol == psrb_pkg::PROTO_UDP) begin
					if ({1'b0, l4} + 17'd8 > {1'b0, item_q.frame_length})
						reason = psrb_pkg::RSN_SHORT_UDP;
					else if (item_q.udp_length_field < min_udp_q)
						reason = psrb_pkg::RSN_TINY_UDP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_HASH;
				ST_HASH: state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_EVAL)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL)
			out_data <= '{verdict: reason != psrb_pkg::RSN_NONE, drop_reason: reason};
	end

	`PSRB_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, in_stall,
		"frame accepted while busy")
	`PSRB_ASSERT_IMPL(a_no_accept_clear, clk, arst_n, !clr_done, in_stall,
		"frame accepted during table sweep")
	`PSRB_ASSERT_NEXT(a_eval_result, clk, arst_n, state_q == ST_EVAL, out_valid,
		"result not posted after evaluation")
	`PSRB_ASSERT_IMPL(a_pass_no_reason, clk, arst_n, out_valid,
		out_data.verdict == (out_data.drop_reason != psrb_pkg::RSN_NONE),
		"verdict and reason disagree")

endmodule
